### rtl/core/deadband_pulse_motor_guard_top_macros.svh
// assertion macros of the deadband pulse motor guard rtl, used by its top level
// needs clk and rst_n in the scope of each use
`ifndef DEADBAND_PULSE_MOTOR_GUARD_TOP_MACROS_SVH
`define DEADBAND_PULSE_MOTOR_GUARD_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DPMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dpmg_pkg.sv
// types, codes and constants of the deadband pulse motor guard
// used by every module of the block, no dependencies
package dpmg_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int LOW_READING     = 10;
    localparam int STALL_DELTA     = 2;

    localparam int DIR_W   = 2;
    localparam int PULSE_W = 2;
    localparam int PAUSE_W = 6;
    localparam int CNT_W   = 7;
    localparam int ERR_W   = 3;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [DIR_W-1:0] DIR_LOCKED = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_A_LOW    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_B_LOW    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BOTH_LOW = 3'd3;
    localparam logic [ERR_W-1:0] ERR_STALL    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OVERTIME = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIM   = 3'd7;

    typedef struct packed {
        logic [2:0]         deadband;
        logic [2:0]         upper_threshold;
        logic [3:0]         lower_threshold;
        logic [PULSE_W-1:0] pulse_ticks;
        logic [PAUSE_W-1:0] pause_ticks;
        logic [CNT_W-1:0]   stall_limit;
        logic [CNT_W-1:0]   overtime_limit;
        logic [CNT_W-1:0]   bad_reading_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        deadband:          3'd0,
        upper_threshold:   3'd4,
        lower_threshold:   4'hc,
        pulse_ticks:       2'd1,
        pause_ticks:       6'd30,
        stall_limit:       7'd10,
        overtime_limit:    7'd99,
        bad_reading_limit: 7'd10
    };

    typedef struct packed {
        logic [DIR_W-1:0]   dir;
        logic [PULSE_W-1:0] pulse_left;
        logic [PAUSE_W-1:0] pause_left;
        logic [CNT_W-1:0]   overtime_count;
        logic [CNT_W-1:0]   stall_count;
        logic [ERR_W-1:0]   error_state;
        logic               fault;
        logic               pulse_on;
    } ctrl_state_t;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        return (c != CNT_MAX) ? c + 1'b1 : c;
    endfunction

endpackage

### rtl/core/dpmg_cfg.sv
// configuration registers of the deadband pulse motor guard
// depends on dpmg_pkg
module dpmg_cfg
    import dpmg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEADBAND:  cfg_next.deadband          = cfg_data[2:0];
                CFG_UPPER:     cfg_next.upper_threshold   = cfg_data[2:0];
                CFG_LOWER:     cfg_next.lower_threshold   = cfg_data[3:0];
                CFG_PULSE:     cfg_next.pulse_ticks       = cfg_data[PULSE_W-1:0];
                CFG_PAUSE:     cfg_next.pause_ticks       = cfg_data[PAUSE_W-1:0];
                CFG_STALL_LIM: cfg_next.stall_limit       = cfg_data;
                CFG_OVER_LIM:  cfg_next.overtime_limit    = cfg_data;
                CFG_BAD_LIM:   cfg_next.bad_reading_limit = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/dpmg_monitor.sv
// low-reading monitor: channel error codes and persistent-fault latch
// depends on dpmg_pkg
module dpmg_monitor
    import dpmg_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic signed [VALUE_WIDTH-1:0] freq_a,
    input  logic signed [VALUE_WIDTH-1:0] freq_b,
    input  logic [CNT_W-1:0]              bad_limit,
    input  ctrl_state_t                   st,
    input  logic [CNT_W-1:0]              bad_count,
    output ctrl_state_t                   st_out,
    output logic [CNT_W-1:0]              bad_count_out
);

    localparam logic signed [VALUE_WIDTH-1:0] LOW_LVL = VALUE_WIDTH'(LOW_READING);

    logic             low_a;
    logic             low_b;
    logic [CNT_W-1:0] cnt_inc;

    assign low_a   = freq_a < LOW_LVL;
    assign low_b   = freq_b < LOW_LVL;
    assign cnt_inc = inc_sat(bad_count);

    always_comb
    begin
        st_out        = st;
        bad_count_out = bad_count;
        if (bad_limit != '0 && (low_a || low_b))
        begin
            bad_count_out = cnt_inc;
            st_out.error_state = (low_a && low_b) ? ERR_BOTH_LOW :
                                 (low_b ? ERR_B_LOW : ERR_A_LOW);
            if (cnt_inc > bad_limit)
            begin
                st_out.fault  = 1'b1;
                bad_count_out = '0;
            end
        end
        else if (bad_count != '0)
        begin
            // good reading ends the episode, also drops a stall or overtime code
            bad_count_out      = '0;
            st_out.error_state = ERR_NONE;
        end
    end

endmodule

### rtl/core/dpmg_drive.sv
// drive controller: deadband lock, hysteresis pulses, stall and overtime checks
// depends on dpmg_pkg
module dpmg_drive
    import dpmg_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic signed [VALUE_WIDTH-1:0] error_value,
    input  cfg_t                          cfg,
    input  ctrl_state_t                   st,
    input  logic [VALUE_WIDTH-1:0]        last_mag,
    output ctrl_state_t                   st_out,
    output logic [VALUE_WIDTH-1:0]        last_mag_out
);

    localparam logic [VALUE_WIDTH-1:0] DELTA = VALUE_WIDTH'(STALL_DELTA);

    logic [VALUE_WIDTH-1:0]        mag;
    logic [VALUE_WIDTH-1:0]        mag_diff;
    logic signed [VALUE_WIDTH-1:0] upper_s;
    logic signed [VALUE_WIDTH-1:0] lower_s;
    logic [VALUE_WIDTH-1:0]        deadband_u;
    logic                          moving;
    logic                          beyond;
    logic                          chan_err;
    logic [CNT_W-1:0]              stall_c;
    logic [VALUE_WIDTH-1:0]        mag_c;
    logic                          stall_trip;
    logic [DIR_W-1:0]              new_dir;
    logic                          start;
    logic [CNT_W-1:0]              over_c;

    // magnitude of the most negative value fits as unsigned
    assign mag        = error_value[VALUE_WIDTH-1] ? (~error_value + 1'b1) : error_value;
    assign mag_diff   = (last_mag > mag) ? (last_mag - mag) : (mag - last_mag);
    assign upper_s    = {{(VALUE_WIDTH-3){1'b0}}, cfg.upper_threshold};
    assign lower_s    = {{(VALUE_WIDTH-4){cfg.lower_threshold[3]}}, cfg.lower_threshold};
    assign deadband_u = {{(VALUE_WIDTH-3){1'b0}}, cfg.deadband};
    assign moving     = st.dir != DIR_LOCKED;
    assign beyond     = error_value >= upper_s || error_value <= lower_s;
    assign chan_err   = st.error_state == ERR_A_LOW || st.error_state == ERR_B_LOW ||
                        st.error_state == ERR_BOTH_LOW;

    // stall tracking on ticks that reach the pulse decision
    always_comb
    begin
        stall_c = st.stall_count;
        mag_c   = last_mag;
        if (cfg.stall_limit != '0 && beyond)
        begin
            if (!moving)
                mag_c = mag;
            else if (mag_diff < DELTA)
                stall_c = inc_sat(st.stall_count);
            else
            begin
                stall_c = '0;
                mag_c   = mag;
            end
        end
    end

    assign stall_trip = cfg.stall_limit != '0 && stall_c > cfg.stall_limit;

    always_comb
    begin
        if (error_value >= upper_s || (error_value > 0 && moving))
            new_dir = DIR_LEFT;
        else if (error_value <= lower_s || (error_value < 0 && moving))
            new_dir = DIR_RIGHT;
        else
            new_dir = DIR_LOCKED;
    end

    assign start  = cfg.pulse_ticks != '0 && new_dir != DIR_LOCKED;
    assign over_c = (start && cfg.overtime_limit != '0) ? inc_sat(st.overtime_count)
                                                       : st.overtime_count;

    always_comb
    begin
        st_out       = st;
        last_mag_out = last_mag;
        if (st.pause_left != '0)
            st_out.pause_left = st.pause_left - 1'b1;
        else if (mag <= deadband_u)
        begin
            if (moving)
            begin
                st_out.overtime_count = '0;
                st_out.stall_count    = '0;
                st_out.pulse_on       = 1'b0;
                st_out.dir            = DIR_LOCKED;
                st_out.pulse_left     = '0;
                st_out.pause_left     = cfg.pause_ticks;
            end
        end
        else if (st.pulse_left != '0)
        begin
            st_out.pulse_left = st.pulse_left - 1'b1;
            if (st.pulse_left == PULSE_W'(1))
            begin
                st_out.pulse_on   = 1'b0;
                st_out.pause_left = cfg.pause_ticks;
            end
        end
        else if (!chan_err)
        begin
            last_mag_out       = mag_c;
            st_out.stall_count = stall_c;
            if (stall_trip)
            begin
                st_out.error_state = ERR_STALL;
                st_out.stall_count = '0;
                st_out.fault       = 1'b1;
            end
            else
            begin
                if (start)
                begin
                    st_out.dir        = new_dir;
                    st_out.pulse_left = cfg.pulse_ticks;
                    st_out.pulse_on   = 1'b1;
                end
                st_out.overtime_count = over_c;
                if (cfg.overtime_limit != '0 && over_c > cfg.overtime_limit)
                begin
                    st_out.error_state    = ERR_OVERTIME;
                    st_out.overtime_count = '0;
                    st_out.fault          = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/deadband_pulse_motor_guard_top.sv
// top level of the deadband pulse motor guard: request register, tick state, result
// depends on dpmg_pkg, dpmg_cfg, dpmg_monitor, dpmg_drive and the assertion macros
//
// One request is one control tick. The block takes a request every clock cycle
// while in_stall is low. A request sits in the input register, then the monitor
// and drive logic update the tick state, whose registers are the result.
// The sustained rate is one tick per cycle when out_stall is low, set by the state
// update loop. While a result is stalled one more request is held in the input
// register, then in_stall rises. Configuration is written through cfg_write,
// cfg_index and cfg_data; write it only while idle, since the block itself does
// not enforce this.
`include "deadband_pulse_motor_guard_top_macros.svh"

module deadband_pulse_motor_guard_top
    import dpmg_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] error_value,
    input  logic signed [VALUE_WIDTH-1:0] freq_a,
    input  logic signed [VALUE_WIDTH-1:0] freq_b,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pulse_active,
    output logic [DIR_W-1:0]              drive_dir,
    output logic                          fault,
    output logic [ERR_W-1:0]              error_code
);

    cfg_t cfg;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [VALUE_WIDTH-1:0] err_reg;
    logic signed [VALUE_WIDTH-1:0] fa_reg;
    logic signed [VALUE_WIDTH-1:0] fb_reg;
    logic                          restart_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          advance;
    logic                          take;

    ctrl_state_t            st_reg;
    ctrl_state_t            st_next;
    ctrl_state_t            st_mon;
    ctrl_state_t            st_drv;
    logic [CNT_W-1:0]       bad_reg;
    logic [CNT_W-1:0]       bad_next;
    logic [CNT_W-1:0]       bad_mon;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic [VALUE_WIDTH-1:0] mag_drv;

    dpmg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpmg_monitor #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_monitor (
        .freq_a        (fa_reg),
        .freq_b        (fb_reg),
        .bad_limit     (cfg.bad_reading_limit),
        .st            (st_reg),
        .bad_count     (bad_reg),
        .st_out        (st_mon),
        .bad_count_out (bad_mon)
    );

    dpmg_drive #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_drive (
        .error_value  (err_reg),
        .cfg          (cfg),
        .st           (st_mon),
        .last_mag     (mag_reg),
        .st_out       (st_drv),
        .last_mag_out (mag_drv)
    );

    // result side frees up when empty or taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        st_next  = st_reg;
        bad_next = bad_reg;
        mag_next = mag_reg;
        if (advance && s1_valid_reg)
        begin
            if (restart_reg)
            begin
                // stall count, last magnitude and bad-reading count survive
                st_next.dir            = DIR_LOCKED;
                st_next.pulse_left     = '0;
                st_next.pause_left     = '0;
                st_next.overtime_count = '0;
                st_next.pulse_on       = 1'b0;
                st_next.fault          = 1'b0;
                st_next.error_state    = ERR_NONE;
            end
            else
            begin
                st_next  = st_drv;
                bad_next = bad_mon;
                mag_next = mag_drv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            bad_reg       <= '0;
            mag_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            bad_reg       <= bad_next;
            mag_reg       <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            err_reg     <= error_value;
            fa_reg      <= freq_a;
            fb_reg      <= freq_b;
            restart_reg <= restart;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pulse_active = st_reg.pulse_on;
    assign drive_dir    = st_reg.dir;
    assign fault        = st_reg.fault;
    assign error_code   = st_reg.error_state;

    `DPMG_ASSERT_NOW(a_pulse_has_dir, st_reg.pulse_on, st_reg.dir != DIR_LOCKED,
        "pulse active while locked")
    `DPMG_ASSERT_NOW(a_pulse_left_on, st_reg.pulse_left != '0, st_reg.pulse_on,
        "pulse countdown running with pulse off")
    `DPMG_ASSERT_NOW(a_pause_no_pulse, st_reg.pause_left != '0, st_reg.pulse_left == '0,
        "pause and pulse countdowns both running")
    `DPMG_ASSERT_NOW(a_motor_fault, st_reg.error_state == ERR_STALL ||
        st_reg.error_state == ERR_OVERTIME, st_reg.fault,
        "stall or overtime code without fault")
    `DPMG_ASSERT_NEXT(a_held_request, s1_valid_reg && !advance, s1_valid_reg,
        "held request dropped")

endmodule
